### hdl/integer_text_parser_macros.svh
// Assertion macros used by the integer text parser core.
`ifndef INTEGER_TEXT_PARSER_MACROS_SVH
`define INTEGER_TEXT_PARSER_MACROS_SVH

// Same-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define ITP_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define ITP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/itp_pkg.sv
// Types, constants and character helpers for the integer text parser.
package itp_pkg;

    localparam int unsigned ACC_W   = 64;
    localparam int unsigned BASE_W  = 5;
    localparam int unsigned WIDTH_W = 8;
    localparam int unsigned FCNT_W  = 9;
    localparam int unsigned TOT_W   = 16;
    localparam int unsigned CFG_AW  = 2;
    localparam int unsigned CFG_DW  = 8;
    localparam int unsigned PROD_W  = ACC_W + BASE_W;

    localparam logic [CFG_AW-1:0] CFG_NUMBER_BASE = 2'd0;
    localparam logic [CFG_AW-1:0] CFG_MAX_WIDTH   = 2'd1;
    localparam logic [CFG_AW-1:0] CFG_SIGNED_MODE = 2'd2;

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LO_X  = 8'h78;
    localparam logic [7:0] CH_UP_X  = 8'h58;
    localparam logic [7:0] CH_LO_A  = 8'h61;
    localparam logic [7:0] CH_LO_F  = 8'h66;
    localparam logic [7:0] CH_UP_A  = 8'h41;
    localparam logic [7:0] CH_UP_F  = 8'h46;

    localparam logic [BASE_W-1:0] BASE_AUTO = 5'd0;
    localparam logic [BASE_W-1:0] BASE_OCT  = 5'd8;
    localparam logic [BASE_W-1:0] BASE_DEC  = 5'd10;
    localparam logic [BASE_W-1:0] BASE_HEX  = 5'd16;

    localparam logic [ACC_W-1:0] SMAX = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [ACC_W-1:0] SMIN = 64'h8000_0000_0000_0000;
    localparam logic [ACC_W-1:0] UMAX = 64'hFFFF_FFFF_FFFF_FFFF;

    localparam logic [FCNT_W-1:0] FCNT_MAX = '1;
    localparam logic [TOT_W-1:0]  TOT_MAX  = '1;

    typedef struct packed {
        logic [BASE_W-1:0]  number_base;
        logic [WIDTH_W-1:0] max_width;
        logic               signed_mode;
    } t_cfg;

    typedef struct packed {
        logic [TOT_W-1:0] consumed_total;
        logic             byte_taken;
        logic             overflowed;
        logic             matched;
        logic [ACC_W-1:0] number_value;
    } t_result;

    typedef struct packed {
        logic       valid;
        logic [3:0] value;
    } t_digit;

    function automatic logic is_white(input logic [7:0] c);
        return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

    // Letters count only when hex is set.
    function automatic t_digit digit_of(input logic [7:0] c, input logic hex);
        t_digit d;
        d.valid = 1'b0;
        d.value = '0;
        if ((c >= CH_ZERO) && (c <= CH_NINE)) begin
            d.valid = 1'b1;
            d.value = 4'(c - CH_ZERO);
        end else if (hex && (c >= CH_LO_A) && (c <= CH_LO_F)) begin
            d.valid = 1'b1;
            d.value = 4'(c - CH_LO_A + 8'd10);
        end else if (hex && (c >= CH_UP_A) && (c <= CH_UP_F)) begin
            d.valid = 1'b1;
            d.value = 4'(c - CH_UP_A + 8'd10);
        end
        return d;
    endfunction

endpackage

### hdl/itp_core.sv
// Parser state and combinational character step with saturating accumulate.
`include "integer_text_parser_macros.svh"

module itp_core
    import itp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_fire,
    input  logic [7:0] i_char,
    input  logic       i_begin,
    input  t_cfg       i_cfg,
    output logic       o_emit,
    output t_result    o_res
);

    typedef enum logic [2:0] {
        PH_SPACE,
        PH_PREFIX,
        PH_ZERO,
        PH_DIGITS,
        PH_DONE
    } t_phase;

    t_phase              r_phase, n_phase;
    logic [ACC_W-1:0]    r_acc, n_acc;
    logic                r_neg, n_neg;
    logic [FCNT_W-1:0]   r_fc, n_fc;
    logic [BASE_W-1:0]   r_eb, n_eb;
    logic                r_ovf, n_ovf;
    logic                r_mat, n_mat;
    logic [TOT_W-1:0]    r_tot, n_tot;

    logic                go;
    logic                consume_ws;
    logic                take_it;
    logic                stop_nondigit;
    logic                width_done;
    logic                auto_base;
    t_digit              dig;
    logic [PROD_W-1:0]   prod;
    logic [PROD_W-1:0]   lim;

    always_comb begin
        n_phase = r_phase;
        n_acc   = r_acc;
        n_neg   = r_neg;
        n_fc    = r_fc;
        n_eb    = r_eb;
        n_ovf   = r_ovf;
        n_mat   = r_mat;
        n_tot   = r_tot;
        if (i_begin) begin
            n_phase = PH_SPACE;
            n_acc   = '0;
            n_neg   = 1'b0;
            n_fc    = '0;
            n_eb    = BASE_DEC;
            n_ovf   = 1'b0;
            n_mat   = 1'b0;
            n_tot   = '0;
        end

        go            = (n_phase != PH_DONE);
        consume_ws    = 1'b0;
        take_it       = 1'b0;
        stop_nondigit = 1'b0;
        auto_base     = (i_cfg.number_base == BASE_AUTO);
        dig           = '0;
        prod          = '0;
        lim           = i_cfg.signed_mode ? PROD_W'(SMAX) : PROD_W'(UMAX);

        if (go && (n_phase == PH_SPACE)) begin
            if (is_white(i_char)) begin
                consume_ws = 1'b1;
                go         = 1'b0;
            end else begin
                n_phase = PH_PREFIX;
                if ((i_char == CH_MINUS) || (i_char == CH_PLUS)) begin
                    n_neg   = (i_char == CH_MINUS);
                    take_it = 1'b1;
                    go      = 1'b0;
                end
            end
        end

        if (go && (n_phase == PH_PREFIX)) begin
            if (auto_base || (i_cfg.number_base == BASE_HEX)) begin
                if (i_char == CH_ZERO) begin
                    n_mat   = 1'b1;
                    n_eb    = auto_base ? BASE_OCT : BASE_HEX;
                    n_phase = PH_ZERO;
                    take_it = 1'b1;
                    go      = 1'b0;
                end else begin
                    n_eb = auto_base ? BASE_DEC : BASE_HEX;
                end
            end else begin
                n_eb = i_cfg.number_base;
            end
            if (go) begin
                n_phase = PH_DIGITS;
            end
        end

        if (go && (n_phase == PH_ZERO)) begin
            n_phase = PH_DIGITS;
            if ((i_char == CH_LO_X) || (i_char == CH_UP_X)) begin
                n_eb    = BASE_HEX;
                take_it = 1'b1;
                go      = 1'b0;
            end
        end

        if (go) begin
            dig  = digit_of(i_char, n_eb == BASE_HEX);
            prod = {{BASE_W{1'b0}}, n_acc} * PROD_W'(n_eb) + PROD_W'(dig.value);
            if (!dig.valid || ({1'b0, dig.value} >= n_eb)) begin
                stop_nondigit = 1'b1;
            end else begin
                n_mat   = 1'b1;
                take_it = 1'b1;
                if (!n_ovf) begin
                    if (prod > lim) begin
                        n_ovf = 1'b1;
                        if (i_cfg.signed_mode) begin
                            n_acc = n_neg ? SMIN : SMAX;
                        end else begin
                            n_acc = UMAX;
                        end
                        n_neg = 1'b0;
                    end else begin
                        n_acc = prod[ACC_W-1:0];
                    end
                end
            end
        end

        if ((consume_ws || take_it) && (n_tot != TOT_MAX)) begin
            n_tot = n_tot + TOT_W'(1);
        end
        if (take_it && (n_fc != FCNT_MAX)) begin
            n_fc = n_fc + FCNT_W'(1);
        end
        width_done = take_it && (i_cfg.max_width != '0)
                     && (n_fc >= FCNT_W'(i_cfg.max_width));
        o_emit = stop_nondigit || width_done;
        if (o_emit) begin
            n_phase = PH_DONE;
        end

        o_res.number_value   = n_neg ? (ACC_W'(0) - n_acc) : n_acc;
        o_res.matched        = n_mat;
        o_res.overflowed     = n_ovf;
        o_res.byte_taken     = take_it;
        o_res.consumed_total = n_tot;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_SPACE;
            r_acc   <= '0;
            r_neg   <= 1'b0;
            r_fc    <= '0;
            r_eb    <= BASE_DEC;
            r_ovf   <= 1'b0;
            r_mat   <= 1'b0;
            r_tot   <= '0;
        end else if (i_fire) begin
            r_phase <= n_phase;
            r_acc   <= n_acc;
            r_neg   <= n_neg;
            r_fc    <= n_fc;
            r_eb    <= n_eb;
            r_ovf   <= n_ovf;
            r_mat   <= n_mat;
            r_tot   <= n_tot;
        end
    end

    `ITP_ASSERT_NEXT(a_emit_ends_parse, i_fire && o_emit, r_phase == PH_DONE, "no DONE after result")
    `ITP_ASSERT_NEXT(a_sat_holds, i_fire && !i_begin && r_ovf, $stable(r_acc), "saturated value moved")
    `ITP_ASSERT_NEXT(a_tot_monotonic, i_fire && !i_begin, r_tot >= $past(r_tot), "count went down")

endmodule

### hdl/integer_text_parser.sv
// Integer text parser top level: config registers, input register, result register.
//
// Parses signed or unsigned 64-bit integers from a byte stream, one character per
// clock while no unread result stalls it. A character with tuser set restarts the
// parser. Leading whitespace is skipped, an optional sign and (in auto or hex
// radix) a 0 / 0x prefix are taken, then digits accumulate with saturation until
// a non-digit arrives or the field width is used up; that character produces one
// result. A character is held in the input register, and its result is written to
// the result register. The per-character step (a 64x5 multiply-add with limit
// compare) is combinational and closes on the parser state registers. Configuration
// writes take effect at once and are expected only while the parser is idle.
module integer_text_parser
    import itp_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [CFG_AW-1:0] i_cfg_addr,
    input  logic [CFG_DW-1:0] i_cfg_data,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [7:0]        s_axis_tdata,   // [7:0] character
    input  logic [0:0]        s_axis_tuser,   // [0] begin_req
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [87:0]       m_axis_tdata    // [63:0] number_value, [64] matched,
                                              // [65] overflowed, [66] byte_taken,
                                              // [82:67] consumed_total, [87:83] zero
);

    t_cfg       r_cfg;
    logic       r_in_valid;
    logic [7:0] r_in_char;
    logic       r_in_begin;
    logic       r_out_valid;
    t_result    r_out;

    logic       fire;
    logic       emit;
    t_result    res;

    assign fire          = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || fire;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {5'd0, r_out};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.number_base <= BASE_AUTO;
            r_cfg.max_width   <= '0;
            r_cfg.signed_mode <= 1'b1;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_NUMBER_BASE: r_cfg.number_base <= i_cfg_data[BASE_W-1:0];
                CFG_MAX_WIDTH:   r_cfg.max_width   <= i_cfg_data[WIDTH_W-1:0];
                CFG_SIGNED_MODE: r_cfg.signed_mode <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_char  <= s_axis_tdata;
            r_in_begin <= s_axis_tuser[0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire && emit) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
        if (fire && emit) begin
            r_out <= res;
        end
    end

    itp_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_char  (r_in_char),
        .i_begin (r_in_begin),
        .i_cfg   (r_cfg),
        .o_emit  (emit),
        .o_res   (res)
    );

endmodule

### sim/integer_text_parser_tb.sv
// Self-checking testbench for integer_text_parser: directed table, random streams, stalls.
`timescale 1ns / 100ps

module integer_text_parser_tb;
    import itp_pkg::*;

    localparam int ITEM_GOAL   = 1450;
    localparam int DRAIN_CYC   = 8;
    localparam int HOLD_CYC    = 80;
    localparam int QUIET_LIMIT = 2000;
    localparam int N_ROWS      = 34;

    localparam logic [BASE_W-1:0] RADIX_ONE = 5'd1;
    localparam logic [BASE_W-1:0] RADIX_BIN = 5'd2;
    localparam logic [BASE_W-1:0] RADIX_TOP = 5'd31;

    typedef enum logic [2:0] {
        SCAN_BLANK, SCAN_PREFIX, SCAN_ZERO, SCAN_DIGITS, SCAN_DONE
    } t_scan;

    typedef struct packed {
        logic       is_cfg;
        logic [7:0] key;    // character, or register index
        logic [7:0] val;    // begin flag, or register value
        logic       typed;
        t_result    want;
    } t_row;

    localparam t_row SCRIPT [N_ROWS] = '{
        '{1'b0, CH_SPACE, 8'd0, 1'b0, '0},
        '{1'b0, CH_MINUS, 8'd0, 1'b0, '0},
        '{1'b0, CH_ZERO,  8'd0, 1'b0, '0},
        '{1'b0, CH_LO_X,  8'd0, 1'b0, '0},
        '{1'b0, "g",      8'd0, 1'b1, '{16'd4, 1'b0, 1'b0, 1'b1, 64'd0}},
        '{1'b0, "A",      8'd0, 1'b0, '0},
        '{1'b1, 8'(CFG_MAX_WIDTH),   8'd1, 1'b0, '0},
        '{1'b0, CH_PLUS,  8'd1, 1'b1, '{16'd1, 1'b1, 1'b0, 1'b0, 64'd0}},
        '{1'b1, 8'(CFG_MAX_WIDTH),   8'd0, 1'b0, '0},
        '{1'b1, 8'(CFG_NUMBER_BASE), 8'd16, 1'b0, '0},
        '{1'b0, CH_TAB,   8'd1, 1'b0, '0},
        '{1'b0, "F",      8'd0, 1'b0, '0},
        '{1'b0, "a",      8'd0, 1'b0, '0},
        '{1'b0, 8'h00,    8'd0, 1'b1, '{16'd3, 1'b0, 1'b0, 1'b1, 64'hFA}},
        '{1'b1, 8'(CFG_NUMBER_BASE), 8'd1, 1'b0, '0},
        '{1'b0, CH_ZERO,  8'd1, 1'b0, '0},
        '{1'b0, "1",      8'd0, 1'b0, '0},
        '{1'b1, 8'(CFG_NUMBER_BASE), 8'd31, 1'b0, '0},
        '{1'b0, "9",      8'd1, 1'b0, '0},
        '{1'b0, "a",      8'd0, 1'b0, '0},
        '{1'b1, 8'(CFG_NUMBER_BASE), 8'd0, 1'b0, '0},
        '{1'b1, 8'(CFG_SIGNED_MODE), 8'd0, 1'b0, '0},
        '{1'b0, CH_MINUS, 8'd1, 1'b0, '0},
        '{1'b0, "1",      8'd0, 1'b0, '0},
        '{1'b0, 8'hFF,    8'd0, 1'b1, '{16'd2, 1'b0, 1'b0, 1'b1, UMAX}},
        '{1'b1, 8'(CFG_NUMBER_BASE), 8'd16, 1'b0, '0},
        '{1'b1, 8'(CFG_MAX_WIDTH),   8'd255, 1'b0, '0},
        '{1'b1, 8'(CFG_SIGNED_MODE), 8'd1, 1'b0, '0},
        '{1'b0, CH_CR,    8'd1, 1'b0, '0},
        '{1'b0, CH_ZERO,  8'd0, 1'b0, '0},
        '{1'b0, CH_UP_X,  8'd0, 1'b0, '0},
        '{1'b0, "f",      8'd0, 1'b0, '0},
        '{1'b0, "/",      8'd0, 1'b0, '0},
        '{1'b0, ":",      8'd1, 1'b1, '{16'd0, 1'b0, 1'b0, 1'b0, 64'd0}}
    };

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_cfg_we = 1'b0;
    logic [CFG_AW-1:0] i_cfg_addr = '0;
    logic [CFG_DW-1:0] i_cfg_data = '0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [7:0]        s_axis_tdata = '0;
    logic [0:0]        s_axis_tuser = '0;
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [87:0]       m_axis_tdata;

    // register copies
    logic [BASE_W-1:0]  cfg_radix = BASE_AUTO;
    logic [WIDTH_W-1:0] cfg_width_lim = '0;
    logic               cfg_signed = 1'b1;

    // parser state
    t_scan             scan_ph;
    logic [ACC_W-1:0]  acc_val;
    logic              is_neg;
    logic [FCNT_W-1:0] field_cnt;
    logic [BASE_W-1:0] eff_radix;
    logic              sat_hit;
    logic              got_digit;
    logic [TOT_W-1:0]  total_cnt;

    t_result numbers_due[$];
    t_result due_r, seen_r;

    int  fail_cnt = 0;
    int  chars_sent = 0;
    int  numbers_checked = 0;
    int  saturated_seen = 0;
    int  settings_used = 0;
    int  quiet_cycles = 0;
    bit  calm = 1'b0;
    bit  hold_req = 1'b0;
    bit  fresh = 1'b0;

    integer_text_parser dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    function automatic void restart_parse();
        scan_ph   = SCAN_BLANK;
        acc_val   = '0;
        is_neg    = 1'b0;
        field_cnt = '0;
        eff_radix = BASE_DEC;
        sat_hit   = 1'b0;
        got_digit = 1'b0;
        total_cnt = '0;
    endfunction

    function automatic void bump_total();
        if (total_cnt != TOT_MAX) total_cnt++;
    endfunction

    // true when the field width is used up
    function automatic bit take_char();
        bump_total();
        if (field_cnt != FCNT_MAX) field_cnt++;
        return (cfg_width_lim != 0) && (field_cnt >= FCNT_W'(cfg_width_lim));
    endfunction

    function automatic bit parse_step(input logic [7:0] ch, input bit beg,
                                      output t_result r, output bit live);
        int          dv;
        bit          fire;
        bit          took;
        bit          handled;
        logic [63:0] lim;
        r = '0;
        live = 1'b0;
        fire = 1'b0;
        took = 1'b1;
        handled = 1'b0;
        if (beg) restart_parse();
        if (scan_ph == SCAN_DONE) return 1'b0;
        live = 1'b1;
        if (scan_ph == SCAN_BLANK) begin
            if (ch == CH_SPACE || (ch >= CH_TAB && ch <= CH_CR)) begin
                bump_total();
                return 1'b0;
            end
            scan_ph = SCAN_PREFIX;
            if (ch == CH_MINUS || ch == CH_PLUS) begin
                is_neg = (ch == CH_MINUS);
                fire = take_char();
                handled = 1'b1;
            end
        end
        if (!handled && scan_ph == SCAN_PREFIX) begin
            if (cfg_radix == BASE_AUTO || cfg_radix == BASE_HEX) begin
                if (ch == CH_ZERO) begin
                    got_digit = 1'b1;
                    eff_radix = (cfg_radix == BASE_AUTO) ? BASE_OCT : BASE_HEX;
                    scan_ph = SCAN_ZERO;
                    fire = take_char();
                    handled = 1'b1;
                end else begin
                    eff_radix = (cfg_radix == BASE_AUTO) ? BASE_DEC : BASE_HEX;
                end
            end else begin
                eff_radix = cfg_radix;
            end
            if (!handled) scan_ph = SCAN_DIGITS;
        end
        if (!handled && scan_ph == SCAN_ZERO) begin
            scan_ph = SCAN_DIGITS;
            if (ch == CH_LO_X || ch == CH_UP_X) begin
                eff_radix = BASE_HEX;
                fire = take_char();
                handled = 1'b1;
            end
        end
        if (!handled) begin
            dv = -1;
            if (ch >= CH_ZERO && ch <= CH_NINE) begin
                dv = int'(ch - CH_ZERO);
            end else if (eff_radix == BASE_HEX) begin
                if (ch >= CH_LO_A && ch <= CH_LO_F) dv = int'(ch - CH_LO_A) + 10;
                else if (ch >= CH_UP_A && ch <= CH_UP_F) dv = int'(ch - CH_UP_A) + 10;
            end
            if (dv < 0 || dv >= int'(eff_radix)) begin
                fire = 1'b1;
                took = 1'b0;
            end else begin
                got_digit = 1'b1;
                if (!sat_hit) begin
                    lim = cfg_signed ? SMAX : UMAX;
                    if (acc_val > (lim - 64'(dv)) / 64'(eff_radix)) begin
                        sat_hit = 1'b1;
                        if (cfg_signed) acc_val = is_neg ? SMIN : SMAX;
                        else acc_val = UMAX;
                        is_neg = 1'b0;
                    end else begin
                        acc_val = acc_val * 64'(eff_radix) + 64'(dv);
                    end
                end
                fire = take_char();
            end
        end
        if (fire) begin
            r.number_value   = is_neg ? (64'd0 - acc_val) : acc_val;
            r.matched        = got_digit;
            r.overflowed     = sat_hit;
            r.byte_taken     = took;
            r.consumed_total = total_cnt;
            scan_ph = SCAN_DONE;
            if (sat_hit) saturated_seen++;
        end
        return fire;
    endfunction

    // mostly short gaps, now and then a long one
    function automatic int idle_len();
        int r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 2);
        if (r < 97) return $urandom_range(3, 8);
        return $urandom_range(15, 40);
    endfunction

    task automatic send_char(input logic [7:0] ch, input bit beg,
                             input bit typed, input t_result want);
        t_result r;
        bit      fire;
        bit      live;
        int      gap;
        gap = idle_len();
        if (gap > 0) begin
            s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = ch;
        s_axis_tuser  = beg;
        do @(posedge i_clk); while (!s_axis_tready);
        fire = parse_step(ch, beg, r, live);
        if (typed) numbers_due.push_back(want);
        else if (fire) numbers_due.push_back(r);
        if (live) chars_sent++;
        @(negedge i_clk);
    endtask

    task automatic put(input logic [7:0] ch);
        send_char(ch, fresh, 1'b0, '0);
        fresh = 1'b0;
    endtask

    task automatic drain_wait();
        s_axis_tvalid = 1'b0;
        while (numbers_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYC) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic cfg_write(input logic [CFG_AW-1:0] addr, input logic [CFG_DW-1:0] data);
        i_cfg_we   = 1'b1;
        i_cfg_addr = addr;
        i_cfg_data = data;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        case (addr)
            CFG_NUMBER_BASE: cfg_radix = data[BASE_W-1:0];
            CFG_MAX_WIDTH:   cfg_width_lim = data[WIDTH_W-1:0];
            CFG_SIGNED_MODE: cfg_signed = data[0];
            default: ;
        endcase
    endtask

    // one number: blanks, sign, 0 / 0x prefix, digits, then any byte; or now and then a run of random bytes
    task automatic send_number();
        int         n_dig;
        int         top;
        int         v;
        bit         lead0;
        bit         hexp;
        logic [7:0] c;
        if ($urandom_range(0, 9) < 2) begin
            repeat ($urandom_range(1, 6))
                send_char(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0, 1'b0, '0);
            return;
        end
        fresh = 1'b1;
        lead0 = 1'b0;
        hexp  = 1'b0;
        if ($urandom_range(0, 9) >= 6) begin
            repeat ($urandom_range(1, 3)) begin
                v = $urandom_range(0, 5);
                put((v == 5) ? CH_SPACE : 8'(CH_TAB + v));
            end
        end
        if ($urandom_range(0, 1)) put($urandom_range(0, 1) ? CH_MINUS : CH_PLUS);
        if ($urandom_range(0, 3) == 0) begin
            put(CH_ZERO);
            lead0 = 1'b1;
            if ($urandom_range(0, 1)) begin
                put($urandom_range(0, 1) ? CH_LO_X : CH_UP_X);
                hexp = 1'b1;
            end
        end
        if (hexp || cfg_radix == BASE_HEX) top = 16;
        else if (cfg_radix == BASE_AUTO) top = lead0 ? 8 : 10;
        else top = (cfg_radix > BASE_DEC) ? 10 : int'(cfg_radix);
        v = $urandom_range(0, 19);
        n_dig = (v < 2) ? 0 : (v < 16) ? $urandom_range(1, 8) : $urandom_range(15, 24);
        repeat (n_dig) begin
            if ($urandom_range(0, 19) == 0) begin
                c = 8'($urandom_range(0, 255));
            end else begin
                v = $urandom_range(0, top - 1);
                if (v < 10) c = 8'(CH_ZERO + v);
                else c = 8'(($urandom_range(0, 1) ? CH_LO_A : CH_UP_A) + v - 10);
            end
            put(c);
        end
        put(8'($urandom_range(0, 255)));
    endtask

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            fail_cnt++;
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (numbers_due.size() == 0) begin
                $error("result %h arrived with nothing outstanding", m_axis_tdata);
                fail_cnt++;
            end else begin
                due_r  = numbers_due.pop_front();
                seen_r = t_result'(m_axis_tdata[82:0]);
                check_field("number_value", due_r.number_value, seen_r.number_value);
                check_field("matched", 64'(due_r.matched), 64'(seen_r.matched));
                check_field("overflowed", 64'(due_r.overflowed), 64'(seen_r.overflowed));
                check_field("byte_taken", 64'(due_r.byte_taken), 64'(seen_r.byte_taken));
                check_field("consumed_total", 64'(due_r.consumed_total),
                            64'(seen_r.consumed_total));
                check_field("pad", 64'd0, 64'(m_axis_tdata[87:83]));
                numbers_checked++;
            end
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == QUIET_LIMIT) begin
            $display("watchdog: no request moved for %0d cycles", QUIET_LIMIT);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // result side: random back-pressure, one long hold on request
    initial begin
        int gap;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                m_axis_tready = 1'b0;
                repeat (HOLD_CYC) @(negedge i_clk);
            end
            gap = idle_len();
            if (gap > 0) begin
                m_axis_tready = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            m_axis_tready = 1'b1;
        end
    end

    initial begin
        int                 phase_no;
        logic [BASE_W-1:0]  rad;
        logic [WIDTH_W-1:0] wid;
        logic               sgn;
        restart_parse();
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (SCRIPT[i]) begin
            if (SCRIPT[i].is_cfg) begin
                drain_wait();
                cfg_write(SCRIPT[i].key[CFG_AW-1:0], SCRIPT[i].val);
            end else begin
                send_char(SCRIPT[i].key, SCRIPT[i].val[0], SCRIPT[i].typed, SCRIPT[i].want);
            end
        end

        phase_no = 0;
        while (chars_sent < ITEM_GOAL) begin
            drain_wait();
            case (phase_no)
                0: begin rad = BASE_AUTO; wid = '0; sgn = 1'b1; end
                1: begin rad = RADIX_TOP; wid = '1; sgn = 1'b0; end
                2: begin rad = RADIX_BIN; wid = 8'd1; sgn = 1'b0; end
                default: begin
                    case ($urandom_range(0, 9))
                        0, 1:    rad = BASE_AUTO;
                        2:       rad = BASE_DEC;
                        3, 4:    rad = BASE_HEX;
                        5:       rad = BASE_OCT;
                        6:       rad = RADIX_BIN;
                        7:       rad = RADIX_ONE;
                        8:       rad = RADIX_TOP;
                        default: rad = 5'($urandom_range(2, 31));
                    endcase
                    case ($urandom_range(0, 9))
                        0, 1, 2, 3, 4: wid = '0;
                        5:             wid = 8'd1;
                        6:             wid = '1;
                        default:       wid = 8'($urandom_range(2, 24));
                    endcase
                    sgn = 1'($urandom_range(0, 1));
                end
            endcase
            cfg_write(CFG_NUMBER_BASE, CFG_DW'(rad));
            cfg_write(CFG_MAX_WIDTH, wid);
            cfg_write(CFG_SIGNED_MODE, CFG_DW'(sgn));
            settings_used++;
            calm = ($urandom_range(0, 3) == 0);
            if (phase_no == 3) begin
                // keep offering while the result side holds off
                calm = 1'b1;
                hold_req = 1'b1;
            end
            repeat ((phase_no == 3) ? 20 : $urandom_range(4, 16)) send_number();
            calm = 1'b0;
            phase_no++;
        end

        drain_wait();
        repeat (DRAIN_CYC) @(posedge i_clk);
        $display("Parsed %0d characters into %0d checked numbers (%0d saturated)",
                 chars_sent, numbers_checked, saturated_seen);
        $display("Random part used %0d register settings, with stalls on both sides",
                 settings_used);
        if (fail_cnt == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
